// ===== design/knss_pkg.sv =====
// shared types and constants for the k-nearest sample select block
`default_nettype none

package knss_pkg;

    localparam int MAX_NEIGHBOURS_DEF = 16;
    localparam int COORD_BITS_DEF     = 12;

    localparam int              CFG_W        = 5;
    localparam logic [CFG_W-1:0] MAXN_RESET  = 5'd15;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    // register byte addresses
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_NEIGHBOURS = 2'd0;

    localparam int COLOUR_W = 24;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_OFFER   = 2'd1,
        CMD_READOUT = 2'd2
    } t_command;

    typedef enum logic {
        RD_IDLE,
        RD_EMIT
    } t_rd_state;

    typedef struct packed {
        logic load;     // offer in flight this cycle
        logic in_list;  // slot below the fill count
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== design/knss_dist.sv =====
// squared distance stage: per-axis squares of the offset to the query point
`default_nettype none

module knss_dist #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_load,
    input  wire logic [COORD_BITS-1:0]   i_query_x,
    input  wire logic [COORD_BITS-1:0]   i_query_y,
    input  wire logic [COORD_BITS-1:0]   i_coord_x,
    input  wire logic [COORD_BITS-1:0]   i_coord_y,
    output logic      [2*COORD_BITS-1:0] o_sq_x,
    output logic      [2*COORD_BITS-1:0] o_sq_y
);

    logic [COORD_BITS-1:0]   w_dx;
    logic [COORD_BITS-1:0]   w_dy;
    logic [2*COORD_BITS-1:0] n_sq_x;
    logic [2*COORD_BITS-1:0] n_sq_y;
    logic [2*COORD_BITS-1:0] r_sq_x;
    logic [2*COORD_BITS-1:0] r_sq_y;

    always_comb begin
        w_dx   = (i_coord_x > i_query_x) ? i_coord_x - i_query_x : i_query_x - i_coord_x;
        w_dy   = (i_coord_y > i_query_y) ? i_coord_y - i_query_y : i_query_y - i_coord_y;
        n_sq_x = {{COORD_BITS{1'b0}}, w_dx} * {{COORD_BITS{1'b0}}, w_dx};
        n_sq_y = {{COORD_BITS{1'b0}}, w_dy} * {{COORD_BITS{1'b0}}, w_dy};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sq_x <= n_sq_x;
            r_sq_y <= n_sq_y;
        end
    end

    assign o_sq_x = r_sq_x;
    assign o_sq_y = r_sq_y;

endmodule

`default_nettype wire

// ===== design/knss_cell.sv =====
// one list slot: compares the offered sample with its entry and shifts
`default_nettype none

module knss_cell
    import knss_pkg::*;
#(
    parameter int DIST_W  = 25,
    parameter int ENTRY_W = 73
) (
    input  wire logic               i_clk,
    input  wire t_cell_ctrl         i_ctrl,
    input  wire logic [ENTRY_W-1:0] i_new_entry,
    input  wire logic               i_ins_prev,
    input  wire logic [ENTRY_W-1:0] i_prev_entry,
    output logic                    o_ins,
    output logic      [ENTRY_W-1:0] o_entry
);

    logic [ENTRY_W-1:0]  r_entry;
    logic [ENTRY_W-1:0]  n_entry;
    logic [DIST_W-1:0]   w_dist;
    logic [DIST_W-1:0]   w_new_dist;
    logic [COLOUR_W-1:0] w_colour;
    logic [COLOUR_W-1:0] w_new_colour;
    logic                w_ins;

    // entry layout: x, y, colour, distance (low bits)
    assign w_dist       = r_entry[DIST_W-1:0];
    assign w_new_dist   = i_new_entry[DIST_W-1:0];
    assign w_colour     = r_entry[DIST_W +: COLOUR_W];
    assign w_new_colour = i_new_entry[DIST_W +: COLOUR_W];

    // an empty slot always takes the sample or its left neighbour
    assign w_ins = !i_ctrl.in_list || (w_new_dist < w_dist) ||
                   ((w_new_dist == w_dist) && (w_colour > w_new_colour));

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.load) begin
            if (i_ins_prev) begin
                n_entry = i_prev_entry;
            end else if (w_ins) begin
                n_entry = i_new_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_ins   = w_ins;
    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ===== design/k_nearest_sample_select.sv =====
// top level of the k-nearest sample select block
//
// Keeps a sorted list of the samples nearest to a query point in a row of
// MAX_NEIGHBOURS cells, one entry per cell. Start and offer words are taken
// one per cycle: the offset squares are registered on entry, and in the next
// cycle every cell compares the sample against its own entry at once and the
// row shifts right behind the insertion point. A readout word holds off the
// input until the last listed entry, or a single word for an empty list, has
// been moved into the output register, as the list is read cell by cell; a
// stalled output holds the readout. No clearing pass is needed after reset.
`default_nettype none

module k_nearest_sample_select
    import knss_pkg::*;
#(
    parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
    parameter int COORD_BITS     = COORD_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input words
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [1:0]              i_command,
    input  wire logic [COORD_BITS-1:0]   i_coord_x,
    input  wire logic [COORD_BITS-1:0]   i_coord_y,
    input  wire logic [7:0]              i_red,
    input  wire logic [7:0]              i_green,
    input  wire logic [7:0]              i_blue,
    // output words
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic      [COORD_BITS-1:0]   o_out_x,
    output logic      [COORD_BITS-1:0]   o_out_y,
    output logic      [2*COORD_BITS:0]   o_out_dist_sq,
    output logic      [7:0]              o_out_red,
    output logic      [7:0]              o_out_green,
    output logic      [7:0]              o_out_blue,
    output logic                         o_out_valid,
    output logic                         o_out_last,
    // register port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_ADDR_W-1:0]   paddr,
    input  wire logic [APB_DATA_W-1:0]   pwdata,
    output logic      [APB_DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int DIST_W  = 2 * COORD_BITS + 1;
    localparam int ENTRY_W = 2 * COORD_BITS + COLOUR_W + DIST_W;
    localparam int CNT_W   = $clog2(MAX_NEIGHBOURS + 1);
    localparam int IDX_W   = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
    localparam int LIM_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // ---------------- register port ----------------
    logic [CFG_W-1:0] r_max_neighbours;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_neighbours <= MAXN_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_MAX_NEIGHBOURS) begin
            r_max_neighbours <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_MAX_NEIGHBOURS) begin
            prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_max_neighbours};
        end
    end

    assign pready = 1'b1;

    // ---------------- entry stage ----------------
    t_rd_state               r_state;
    t_rd_state               n_state;
    logic                    w_accept;
    logic                    r_s1_valid;
    logic [1:0]              r_s1_cmd;
    logic [COORD_BITS-1:0]   r_s1_x;
    logic [COORD_BITS-1:0]   r_s1_y;
    logic [COLOUR_W-1:0]     r_s1_colour;
    logic [COORD_BITS-1:0]   r_query_x;
    logic [COORD_BITS-1:0]   r_query_y;
    logic [2*COORD_BITS-1:0] w_sq_x;
    logic [2*COORD_BITS-1:0] w_sq_y;

    // hold off while a readout is pending or running
    assign o_stall  = (r_state == RD_EMIT) || (r_s1_valid && r_s1_cmd == CMD_READOUT);
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_query_x  <= '0;
            r_query_y  <= '0;
        end else begin
            r_s1_valid <= w_accept;
            if (w_accept && i_command == CMD_START) begin
                r_query_x <= i_coord_x;
                r_query_y <= i_coord_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd    <= i_command;
            r_s1_x      <= i_coord_x;
            r_s1_y      <= i_coord_y;
            r_s1_colour <= {i_red, i_green, i_blue};
        end
    end

    knss_dist #(
        .COORD_BITS(COORD_BITS)
    ) u_dist (
        .i_clk    (i_clk),
        .i_load   (w_accept),
        .i_query_x(r_query_x),
        .i_query_y(r_query_y),
        .i_coord_x(i_coord_x),
        .i_coord_y(i_coord_y),
        .o_sq_x   (w_sq_x),
        .o_sq_y   (w_sq_y)
    );

    // ---------------- cell row ----------------
    logic [CNT_W-1:0]   r_count;
    logic [DIST_W-1:0]  w_dist;
    logic [ENTRY_W-1:0] w_new_entry;
    logic               w_offer;
    logic [LIM_W-1:0]   w_lim;
    logic [LIM_W-1:0]   w_cfg_ext;
    logic [ENTRY_W-1:0] w_entry [MAX_NEIGHBOURS];
    logic               w_ins   [MAX_NEIGHBOURS];

    assign w_dist      = {1'b0, w_sq_x} + {1'b0, w_sq_y};
    assign w_new_entry = {r_s1_x, r_s1_y, r_s1_colour, w_dist};
    assign w_offer     = r_s1_valid && r_s1_cmd == CMD_OFFER;

    // limit saturates at the row length
    assign w_cfg_ext = LIM_W'(r_max_neighbours);
    assign w_lim     = (w_cfg_ext > LIM_W'(MAX_NEIGHBOURS)) ? LIM_W'(MAX_NEIGHBOURS) : w_cfg_ext;

    for (genvar g = 0; g < MAX_NEIGHBOURS; g++) begin : g_cell
        t_cell_ctrl w_ctrl;

        assign w_ctrl.load    = w_offer;
        assign w_ctrl.in_list = CNT_W'(g) < r_count;

        if (g == 0) begin : g_head
            knss_cell #(
                .DIST_W (DIST_W),
                .ENTRY_W(ENTRY_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_new_entry (w_new_entry),
                .i_ins_prev  (1'b0),
                .i_prev_entry({ENTRY_W{1'b0}}),
                .o_ins       (w_ins[g]),
                .o_entry     (w_entry[g])
            );
        end else begin : g_body
            knss_cell #(
                .DIST_W (DIST_W),
                .ENTRY_W(ENTRY_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_new_entry (w_new_entry),
                .i_ins_prev  (w_ins[g-1]),
                .i_prev_entry(w_entry[g-1]),
                .o_ins       (w_ins[g]),
                .o_entry     (w_entry[g])
            );
        end
    end

    // a full list keeps its length: the last entry drops out of the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_s1_valid && r_s1_cmd == CMD_START) begin
            r_count <= '0;
        end else if (w_offer && LIM_W'(r_count) < w_lim) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // ---------------- readout ----------------
    logic [IDX_W-1:0]   r_rd_idx;
    logic               w_emit;
    logic               w_last;
    logic [ENTRY_W-1:0] w_rd_entry;
    logic               r_o_valid;
    logic [ENTRY_W-1:0] r_o_entry;
    logic               r_o_present;
    logic               r_o_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            RD_IDLE: begin
                if (r_s1_valid && r_s1_cmd == CMD_READOUT) begin
                    n_state = RD_EMIT;
                end
            end
            RD_EMIT: begin
                if (w_emit && w_last) begin
                    n_state = RD_IDLE;
                end
            end
            default: n_state = RD_IDLE;
        endcase
    end

    always_comb begin
        w_emit = (r_state == RD_EMIT) && (!r_o_valid || !i_stall);
        w_last = (r_count == '0) || (CNT_W'(r_rd_idx) + CNT_W'(1) == r_count);
    end

    assign w_rd_entry = w_entry[r_rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= RD_IDLE;
            r_rd_idx  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == RD_IDLE) begin
                r_rd_idx <= '0;
            end else if (w_emit) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // empty list gives a single word with an all-zero entry, marked last
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_entry   <= (r_count == '0) ? '0 : w_rd_entry;
            r_o_present <= (r_count != '0);
            r_o_last    <= w_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_x       = r_o_entry[ENTRY_W-1 -: COORD_BITS];
    assign o_out_y       = r_o_entry[ENTRY_W-COORD_BITS-1 -: COORD_BITS];
    assign o_out_dist_sq = r_o_entry[DIST_W-1:0];
    assign o_out_red     = r_o_entry[DIST_W+16 +: 8];
    assign o_out_green   = r_o_entry[DIST_W+8 +: 8];
    assign o_out_blue    = r_o_entry[DIST_W +: 8];
    assign o_out_valid   = r_o_present;
    assign o_out_last    = r_o_last;

endmodule

`default_nettype wire
